// File: design/sltab_pkg.sv
// shared constants and types for the sorted list table
`timescale 1ns / 1ps
`default_nettype none

package sltab_pkg;

   // table geometry
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   // transaction field widths
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 16;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                     do_insert;
      logic                     do_remove;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

   // compare flags a cell reports
   typedef struct packed {
      logic gt;
      logic ge;
   } cell_flag_type;

endpackage

`default_nettype wire

// File: design/sltab_cell.sv
// one slot of the sorted table: holds an entry, compares and shifts
`timescale 1ns / 1ps
`default_nettype none

module sltab_cell (
   input  wire logic                              clock,
   input  wire sltab_pkg::cell_cmd_type           cmd,
   input  wire logic                              occ,
   input  wire logic                              tail,
   input  wire logic signed [sltab_pkg::DATA_W-1:0] left_entry,
   input  wire logic                              left_gt,
   input  wire logic signed [sltab_pkg::DATA_W-1:0] right_entry,
   output logic signed [sltab_pkg::DATA_W-1:0]      entry,
   output sltab_pkg::cell_flag_type                 flags
);
   import sltab_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic                     gt;
   logic                     eq;

   // compare against the broadcast value, only for occupied slots
   assign gt = occ && (entry_ff > cmd.value);
   assign eq = occ && (entry_ff == cmd.value);

   // insert shifts larger entries up, remove pulls from the right
   always_comb begin
      entry_in = entry_ff;
      if (cmd.do_insert && (gt || tail)) begin
         entry_in = left_gt ? left_entry : cmd.value;
      end else if (cmd.do_remove && (gt || eq)) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   assign flags.gt = gt;
   assign flags.ge = gt || eq;

endmodule

`default_nettype wire

// File: design/sorted_list_table.sv
// sorted list table top level: chain of cells, fill count and result register
//
//  channel | dir | tdata bits                                   | tuser
//  req_    | in  | operation[1:0] value[33:2] zero[39:34]       | none
//  rsp_    | out | status[1:0] position[5:2] count[10:6] zero   | none
//
//  One transaction per cycle while req_tready is high: every cell compares and shifts in the same cycle.
//  The result is registered; the answer is presented in the cycle after acceptance.
//  req_tready drops only while a result waits and rsp_tready is low.
//  Reset clears the fill count and the result valid; entries need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // operation[1:0], value[33:2], zero fill[39:34]
   input  wire logic [sltab_pkg::REQ_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // status[1:0], position[5:2], count[10:6], zero fill[15:11]
   output logic [sltab_pkg::RSP_W-1:0]      rsp_tdata
);
   import sltab_pkg::*;

   logic                     accept;
   op_type                   op_w;
   logic signed [DATA_W-1:0] value_w;
   cell_cmd_type             cmd;

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               status_ff;
   status_type               status_in;
   logic [IDX_W-1:0]         position_ff;
   logic [IDX_W-1:0]         position_in;
   logic [CNT_W-1:0]         rsp_count_ff;

   logic signed [DATA_W-1:0] entry_w [CAPACITY];
   cell_flag_type            flag_w  [CAPACITY];
   logic [CAPACITY-1:0]      occ_vec;
   logic [CAPACITY-1:0]      gt_vec;
   logic [CAPACITY-1:0]      ge_vec;
   logic [CNT_W-1:0]         le_cnt;
   logic [CNT_W-1:0]         lt_cnt;
   logic                     full;
   logic                     found;

   // input unpacking and handshake
   assign op_w       = op_type'(req_tdata[OP_W-1:0]);
   assign value_w    = req_tdata[OP_W+DATA_W-1:OP_W];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_entry;
      logic                     left_gt;
      logic signed [DATA_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = cmd.value;
         assign left_gt    = 1'b0;
      end else begin : g_mid
         assign left_entry = entry_w[i-1];
         assign left_gt    = flag_w[i-1].gt;
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_inner
         assign right_entry = entry_w[i+1];
      end

      assign occ_vec[i] = count_ff > CNT_W'(i);
      assign gt_vec[i]  = flag_w[i].gt;
      assign ge_vec[i]  = flag_w[i].ge;

      sltab_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occ         (occ_vec[i]),
         .tail        (count_ff == CNT_W'(i)),
         .left_entry  (left_entry),
         .left_gt     (left_gt),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .flags       (flag_w[i])
      );
   end

   // landing point and match summary
   assign le_cnt = CNT_W'($countones(occ_vec & ~gt_vec));
   assign lt_cnt = CNT_W'($countones(occ_vec & ~ge_vec));
   assign full   = count_ff == CNT_W'(CAPACITY);
   assign found  = |(ge_vec & ~gt_vec);

   // operation decode
   always_comb begin
      cmd.value     = value_w;
      cmd.do_insert = 1'b0;
      cmd.do_remove = 1'b0;
      count_in      = count_ff;
      status_in     = ST_OK;
      position_in   = '0;
      unique case (op_w)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.do_insert = accept;
               count_in      = count_ff + CNT_W'(1);
               position_in   = le_cnt[IDX_W-1:0];
            end
         end
         OP_REMOVE: begin
            if (!found) begin
               status_in = ST_NOT_FOUND;
            end else begin
               cmd.do_remove = accept;
               count_in      = count_ff - CNT_W'(1);
               position_in   = lt_cnt[IDX_W-1:0];
            end
         end
         default: begin
            if (!found) begin
               status_in = ST_NOT_FOUND;
            end else begin
               position_in = lt_cnt[IDX_W-1:0];
            end
         end
      endcase
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         position_ff  <= position_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, position_ff, status_ff});

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && (rsp_count_ff == count_ff))
      else $error("reported count differs from fill count");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      accept && (op_w == OP_INSERT) && full |=> (status_ff == ST_FULL) && $stable(count_ff))
      else $error("insert into full table not refused");

   a_fail_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != ST_OK) |-> position_ff == '0)
      else $error("failed transaction reports nonzero position");

endmodule

`default_nettype wire

// File: test/tb.sv
// self-checking testbench for the sorted list table: directed rows, then random phases
`timescale 1ns / 1ps

module tb;
   import sltab_pkg::*;

   // the one code the package leaves unnamed; the block answers it as a search
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // cycles without any transaction before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 40;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 60;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] position;
      logic [CNT_W-1:0] count;
   } answer_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] value;
      logic              typed;
      answer_type        answer;
   } stim_row_type;

   // directed rows; typed answers are checked as written, the rest go through the predictor
   localparam stim_row_type DIRECTED_ROWS [25] = '{
      '{OP_SEARCH, 32'd0,          1'b1, '{ST_NOT_FOUND, 4'd0, 5'd0}},
      '{OP_REMOVE, 32'd5,          1'b1, '{ST_NOT_FOUND, 4'd0, 5'd0}},
      '{OP_INSERT, 32'h7FFF_FFFF,  1'b1, '{ST_OK,        4'd0, 5'd1}},
      '{OP_INSERT, 32'h8000_0000,  1'b1, '{ST_OK,        4'd0, 5'd2}},
      '{OP_SEARCH, 32'h8000_0000,  1'b1, '{ST_OK,        4'd0, 5'd2}},
      '{OP_SEARCH, 32'h7FFF_FFFF,  1'b1, '{ST_OK,        4'd1, 5'd2}},
      '{OP_INSERT, 32'd0,          1'b1, '{ST_OK,        4'd1, 5'd3}},
      // equal value lands after the existing one
      '{OP_INSERT, 32'd0,          1'b1, '{ST_OK,        4'd2, 5'd4}},
      '{OP_INSERT, 32'hFFFF_FFFF,  1'b1, '{ST_OK,        4'd1, 5'd5}},
      // duplicates report the lowest index
      '{OP_SEARCH, 32'd0,          1'b1, '{ST_OK,        4'd2, 5'd5}},
      '{OP_UNUSED, 32'd0,          1'b1, '{ST_OK,        4'd2, 5'd5}},
      // fill the table up to capacity
      '{OP_INSERT, 32'd7,          1'b0, '{ST_OK,        4'd0, 5'd0}},
      '{OP_INSERT, -32'sd7,        1'b0, '{ST_OK,        4'd0, 5'd0}},
      '{OP_INSERT, 32'd3,          1'b0, '{ST_OK,        4'd0, 5'd0}},
      '{OP_INSERT, 32'h7FFF_FFFE,  1'b0, '{ST_OK,        4'd0, 5'd0}},
      '{OP_INSERT, 32'h8000_0001,  1'b0, '{ST_OK,        4'd0, 5'd0}},
      '{OP_INSERT, 32'd100,        1'b0, '{ST_OK,        4'd0, 5'd0}},
      '{OP_INSERT, -32'sd100,      1'b0, '{ST_OK,        4'd0, 5'd0}},
      '{OP_INSERT, 32'd0,          1'b0, '{ST_OK,        4'd0, 5'd0}},
      '{OP_INSERT, 32'd1,          1'b0, '{ST_OK,        4'd0, 5'd0}},
      '{OP_INSERT, 32'd2,          1'b0, '{ST_OK,        4'd0, 5'd0}},
      '{OP_INSERT, 32'd0,          1'b0, '{ST_OK,        4'd0, 5'd0}},
      // insert into a full table is refused
      '{OP_INSERT, 32'd5,          1'b1, '{ST_FULL,      4'd0, 5'd16}},
      '{OP_REMOVE, 32'd0,          1'b0, '{ST_OK,        4'd0, 5'd0}},
      '{OP_REMOVE, 32'h1234_5678,  1'b1, '{ST_NOT_FOUND, 4'd0, 5'd15}}
   };

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;

   // answer typed in the directed table, travels alongside the request
   logic               fixed_valid  = 1'b0;
   answer_type         fixed_answer = '0;

   // idling controls shared by sender and receiver
   logic               steady    = 1'b0;
   logic               want_hold = 1'b0;

   // shadow copy of the table and the answers still awaited
   logic signed [DATA_W-1:0] shadow_list [CAPACITY];
   int                       shadow_fill = 0;
   answer_type               awaited_answers [$];
   int                       mismatches  = 0;
   int                       idle_cycles = 0;

   sorted_list_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // apply one operation to the shadow table and return the answer it yields
   function automatic answer_type list_apply(input logic [OP_W-1:0] op,
                                             input logic signed [DATA_W-1:0] v);
      answer_type a;
      int         i;
      int         at;
      a.status   = ST_OK;
      a.position = '0;
      if (op == OP_INSERT) begin
         if (shadow_fill >= CAPACITY) begin
            a.status = ST_FULL;
         end else begin
            i = shadow_fill;
            while (i > 0 && shadow_list[i-1] > v) begin
               shadow_list[i] = shadow_list[i-1];
               i--;
            end
            shadow_list[i] = v;
            shadow_fill++;
            a.position = IDX_W'(i);
         end
      end else begin
         // lowest matching index, or the fill count when absent
         at = shadow_fill;
         for (i = shadow_fill - 1; i >= 0; i--)
            if (shadow_list[i] == v) at = i;
         if (at == shadow_fill) begin
            a.status = ST_NOT_FOUND;
         end else begin
            a.position = IDX_W'(at);
            if (op == OP_REMOVE) begin
               for (i = at; i < shadow_fill - 1; i++)
                  shadow_list[i] = shadow_list[i+1];
               shadow_fill--;
            end
         end
      end
      a.count = CNT_W'(shadow_fill);
      return a;
   endfunction

   function automatic logic [OP_W-1:0] draw_op(input int insert_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) return OP_INSERT;
      if (roll >= 97) return OP_UNUSED;
      if (roll < insert_pct + (97 - insert_pct) * 6 / 10) return OP_REMOVE;
      return OP_SEARCH;
   endfunction

   // mostly a narrow pool so that hits and duplicates are common
   function automatic logic [DATA_W-1:0] draw_value();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 6) return DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
      if (kind == 6) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h8000_0001;
            2: return 32'h7FFF_FFFE;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      return $urandom();
   endfunction

   function automatic void flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   // offer one request, after a random gap unless steady, and wait for its transaction
   task automatic offer_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v,
                                input logic typed, input answer_type fixed);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= {{(REQ_W - DATA_W - OP_W){1'b0}}, v, op};
      fixed_valid  <= typed;
      fixed_answer <= fixed;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (awaited_answers.size() != 0) @(posedge clock);
   endtask

   // request side: predict at acceptance
   always @(posedge clock) begin : request_monitor
      answer_type a;
      if (!reset && req_tvalid && req_tready) begin
         a = list_apply(req_tdata[OP_W-1:0], req_tdata[OP_W+DATA_W-1:OP_W]);
         if (fixed_valid) a = fixed_answer;
         awaited_answers.push_back(a);
      end
   end

   // result side: compare with the oldest awaited answer
   always @(posedge clock) begin : result_checker
      answer_type want;
      answer_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = status_type'(rsp_tdata[1:0]);
         got.position = rsp_tdata[5:2];
         got.count    = rsp_tdata[10:6];
         if (awaited_answers.size() == 0) begin
            flag_mismatch($sformatf("result 0x%h with nothing awaited", rsp_tdata));
         end else begin
            want = awaited_answers.pop_front();
            if (got.status !== want.status)
               flag_mismatch($sformatf("status expected %0d, got %0d",
                                       want.status, got.status));
            if (got.position !== want.position)
               flag_mismatch($sformatf("position expected %0d, got %0d",
                                       want.position, got.position));
            if (got.count !== want.count)
               flag_mismatch($sformatf("count expected %0d, got %0d",
                                       want.count, got.count));
         end
      end
   end

   // receiver: random stall per result unless steady, one long hold-off on request
   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 4);
         if (want_hold) begin
            stall     = HOLD_CYCLES;
            want_hold = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   initial begin : stimulus
      answer_type no_answer;
      int         r;
      int         ph;
      int         n;
      int         pct;
      no_answer = '{ST_OK, '0, '0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (r = 0; r < 25; r++)
         offer_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].value,
                       DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].answer);

      // random phases: fill-heavy, balanced and drain-heavy in turn
      for (ph = 0; ph < PHASES; ph++) begin
         steady = (ph % 4 == 3);
         if (ph == 5) want_hold = 1'b1;
         pct = (ph % 3 == 0) ? 85 : (ph % 3 == 1) ? 50 : 15;
         for (n = 0; n < PHASE_ITEMS; n++)
            offer_request(draw_op(pct), draw_value(), 1'b0, no_answer);
         // sender pause until every result is back
         if (ph == 7) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (5) @(posedge clock);
      if (mismatches == 0 && awaited_answers.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
